FILE: rtl/box_iou_ratio_assert.svh
// ----------------------------------------------------------------------------
// box_iou_ratio_assert.svh
// Assertion macros shared by the intersection-over-union RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_IOU_RATIO_ASSERT_SVH
`define BOX_IOU_RATIO_ASSERT_SVH

// Same-cycle implication on clk, checked outside rst.
`define BIOU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box_iou_ratio: same-cycle check failed");

// Next-cycle implication on clk, checked outside rst.
`define BIOU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box_iou_ratio: next-cycle check failed");

`endif

FILE: rtl/biou_pkg.sv
// ----------------------------------------------------------------------------
// biou_pkg
// Fixed constants and types for the intersection-over-union pipeline.
// ----------------------------------------------------------------------------
package biou_pkg;

  // Ratio format: unsigned Q1.15
  localparam int RATIO_BITS = 15;
  localparam int RATIO_W    = RATIO_BITS + 1;
  localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1) << RATIO_BITS;
  localparam logic [RATIO_W-1:0] RATIO_ZERO = '0;

  // Pipeline layout: four arithmetic stages, one decision stage, one
  // stage per quotient bit
  localparam int ARITH_STAGES = 4;
  localparam int PIPE_STAGES  = ARITH_STAGES + 1 + RATIO_BITS;

  // Status carried down the divider
  typedef struct packed {
    logic disjoint;
    logic clipped;
    logic fixed;     // result settled before the divide
  } biou_flags_t;

endpackage

FILE: rtl/box_iou_ratio.sv
// ----------------------------------------------------------------------------
// box_iou_ratio
// Intersection over union of two axis-aligned boxes, fully pipelined.
// ----------------------------------------------------------------------------
//
//   channel  | ports                              | direction
//   ---------+------------------------------------+----------
//   pair     | pair_valid/pair_stall, a_*, b_*    | in
//   result   | result_valid/result_stall,         | out
//            | overlap_ratio, disjoint, clipped   |
//
// One box pair per cycle while the result channel is not stalled; 4 arithmetic
// stages, one decision stage, one restoring-divide stage per quotient bit.
// Each stage holds its item only while the stage after it is full and
// stalled, so bubbles close up and new pairs enter while a result waits.
// Synchronous active-high reset clears the valid bits; data is not reset.
// ----------------------------------------------------------------------------
`include "box_iou_ratio_assert.svh"

module box_iou_ratio
  import biou_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pair_valid,
  output logic                          pair_stall,
  input  logic signed [COORD_WIDTH-1:0] a_left,
  input  logic signed [COORD_WIDTH-1:0] a_top,
  input  logic signed [COORD_WIDTH-1:0] a_right,
  input  logic signed [COORD_WIDTH-1:0] a_bottom,
  input  logic signed [COORD_WIDTH-1:0] b_left,
  input  logic signed [COORD_WIDTH-1:0] b_top,
  input  logic signed [COORD_WIDTH-1:0] b_right,
  input  logic signed [COORD_WIDTH-1:0] b_bottom,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [RATIO_W-1:0]            overlap_ratio,
  output logic                          disjoint,
  output logic                          clipped
);

  localparam int DW = COORD_WIDTH + 1;  // edge difference
  localparam int PW = 2 * DW;           // area product
  localparam int UW = PW + 2;           // union sum

  // --------------------------------------------------------------------------
  // Valid bits and per-stage load enables
  // --------------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES:0]   ld;

  assign ld[PIPE_STAGES] = !result_stall;

  for (genvar j = 0; j < PIPE_STAGES; j++) begin : g_ld
    assign ld[j] = !vld[j] || ld[j+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= pair_valid;
      end
      for (int j = 1; j < PIPE_STAGES; j++) begin
        if (ld[j]) begin
          vld[j] <= vld[j-1];
        end
      end
    end
  end

  assign pair_stall   = !ld[0];
  assign result_valid = vld[PIPE_STAGES-1];

  // --------------------------------------------------------------------------
  // Stage 1: intersection edges, box extents, empty test
  // --------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] il_next, it_next, ir_next, ib_next;
  logic signed [COORD_WIDTH-1:0] s1_il, s1_it, s1_ir, s1_ib;
  logic signed [DW-1:0]          s1_dxa, s1_dya, s1_dxb, s1_dyb;
  logic                          s1_dis;

  always_comb begin
    il_next = (a_left   > b_left)   ? a_left   : b_left;
    it_next = (a_top    > b_top)    ? a_top    : b_top;
    ir_next = (b_right  < a_right)  ? b_right  : a_right;
    ib_next = (b_bottom < a_bottom) ? b_bottom : a_bottom;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_il  <= il_next;
      s1_it  <= it_next;
      s1_ir  <= ir_next;
      s1_ib  <= ib_next;
      s1_dis <= (ir_next < il_next) || (ib_next < it_next);
      s1_dxa <= DW'(a_right)  - DW'(a_left);
      s1_dya <= DW'(a_bottom) - DW'(a_top);
      s1_dxb <= DW'(b_right)  - DW'(b_left);
      s1_dyb <= DW'(b_bottom) - DW'(b_top);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: intersection extents
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] s2_iw, s2_ih, s2_dxa, s2_dya, s2_dxb, s2_dyb;
  logic                 s2_dis;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_iw  <= DW'(s1_ir) - DW'(s1_il);
      s2_ih  <= DW'(s1_ib) - DW'(s1_it);
      s2_dxa <= s1_dxa;
      s2_dya <= s1_dya;
      s2_dxb <= s1_dxb;
      s2_dyb <= s1_dyb;
      s2_dis <= s1_dis;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: the three areas
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s3_inter, s3_area_a, s3_area_b;
  logic                 s3_dis;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_inter  <= s2_iw  * s2_ih;
      s3_area_a <= s2_dxa * s2_dya;
      s3_area_b <= s2_dxb * s2_dyb;
      s3_dis    <= s2_dis;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: union
  // --------------------------------------------------------------------------
  logic signed [UW-1:0] s4_uni, s4_inter;
  logic                 s4_dis;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_uni   <= UW'(s3_area_a) + UW'(s3_area_b) - UW'(s3_inter);
      s4_inter <= UW'(s3_inter);
      s4_dis   <= s3_dis;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: special cases, divider setup
  // --------------------------------------------------------------------------
  logic [UW-1:0]      dv_rem   [RATIO_BITS+1];
  logic [UW-1:0]      dv_uni   [RATIO_BITS+1];
  logic [RATIO_W-1:0] dv_ratio [RATIO_BITS+1];
  biou_flags_t        dv_flags [RATIO_BITS+1];

  biou_flags_t        flags_next;
  logic [RATIO_W-1:0] ratio_init;

  always_comb begin
    flags_next = '0;
    ratio_init = RATIO_ZERO;
    priority if (s4_dis) begin
      flags_next.disjoint = 1'b1;
      flags_next.fixed    = 1'b1;
    end else if (s4_uni <= UW'(0)) begin
      flags_next.clipped = 1'b1;
      flags_next.fixed   = 1'b1;
    end else if (s4_uni < s4_inter) begin
      flags_next.clipped = 1'b1;
      flags_next.fixed   = 1'b1;
      ratio_init         = RATIO_ONE;
    end else if (s4_uni == s4_inter) begin
      flags_next.fixed = 1'b1;
      ratio_init       = RATIO_ONE;
    end else begin
      flags_next.fixed = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ARITH_STAGES]) begin
      dv_rem[0]   <= s4_inter;
      dv_uni[0]   <= s4_uni;
      dv_ratio[0] <= ratio_init;
      dv_flags[0] <= flags_next;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divide, one quotient bit per stage
  // For unsettled items 0 <= rem < uni, so the doubled remainder never overflows.
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= RATIO_BITS; k++) begin : g_div
    logic [UW-1:0] rem2;
    logic          ge;

    assign rem2 = {dv_rem[k-1][UW-2:0], 1'b0};
    assign ge   = (rem2 >= dv_uni[k-1]);

    always_ff @(posedge clk) begin
      if (ld[ARITH_STAGES+k]) begin
        dv_rem[k]   <= ge ? (rem2 - dv_uni[k-1]) : rem2;
        dv_uni[k]   <= dv_uni[k-1];
        dv_flags[k] <= dv_flags[k-1];
        dv_ratio[k] <= dv_flags[k-1].fixed ? dv_ratio[k-1]
                                           : {dv_ratio[k-1][RATIO_W-2:0], ge};
      end
    end
  end

  assign overlap_ratio = dv_ratio[RATIO_BITS];
  assign disjoint      = dv_flags[RATIO_BITS].disjoint;
  assign clipped       = dv_flags[RATIO_BITS].clipped;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BIOU_ASSERT_NOW(a_flags_excl, result_valid, !(disjoint && clipped))
  `BIOU_ASSERT_NOW(a_disjoint_zero, result_valid && disjoint, overlap_ratio == RATIO_ZERO)
  `BIOU_ASSERT_NOW(a_ratio_range, result_valid, overlap_ratio <= RATIO_ONE)
  `BIOU_ASSERT_NOW(a_clip_value, result_valid && clipped, overlap_ratio[RATIO_BITS-1:0] == '0)
  `BIOU_ASSERT_NOW(a_empty_accepts, !result_valid, !pair_stall)
  `BIOU_ASSERT_NEXT(a_out_held, result_valid && result_stall, result_valid && $stable(overlap_ratio))

endmodule
